// ===== hdl/csm_pkg.sv =====
// ----------------------------------------------------------------------------
// Clock set menu package
// Request and result types, menu state codes and calendar helpers.
// ----------------------------------------------------------------------------
package csm_pkg;

  localparam logic [2:0] MENU_RUN     = 3'd0;
  localparam logic [2:0] MENU_HOURS   = 3'd1;
  localparam logic [2:0] MENU_MINUTES = 3'd2;
  localparam logic [2:0] MENU_SECONDS = 3'd3;
  localparam logic [2:0] MENU_MONTH   = 3'd4;
  localparam logic [2:0] MENU_DATE    = 3'd5;
  localparam logic [2:0] MENU_YEAR    = 3'd6;
  localparam logic [2:0] MENU_UNUSED  = 3'd7;

  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;

  typedef struct packed {
    logic [5:0] read_seconds;
    logic [5:0] read_minutes;
    logic [4:0] read_hours;
    logic [4:0] read_date;
    logic [3:0] read_month;
    logic [6:0] read_year;
    logic       mode_press;
    logic       up_press;
  } csm_req_t;

  typedef struct packed {
    logic [2:0] shown_state;
    logic [5:0] out_seconds;
    logic [5:0] out_minutes;
    logic [4:0] out_hours;
    logic [4:0] out_date;
    logic [3:0] out_month;
    logic [6:0] out_year;
    logic       write_strobe;
    logic       clear_display;
  } csm_res_t;

  typedef struct packed {
    logic [2:0] menu;
    logic [4:0] hours;
    logic [4:0] date;
    logic [3:0] month;
    logic [6:0] year;
  } csm_state_t;

  function automatic logic csm_short_month(input logic [3:0] month);
    return (month == MONTH_APR) || (month == MONTH_JUN) ||
           (month == MONTH_SEP) || (month == MONTH_NOV);
  endfunction

  function automatic logic [4:0] csm_month_len(input logic [3:0] month,
                                               input logic [6:0] year);
    logic [4:0] len;
    if (month == MONTH_FEB) begin
      len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
    end else if (csm_short_month(month)) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

// ===== hdl/csm_step.sv =====
// ----------------------------------------------------------------------------
// Clock set menu step
// Next menu state, shadow record and result for one request.
// ----------------------------------------------------------------------------
module csm_step import csm_pkg::*; (
  input  csm_req_t   req_i,
  input  csm_state_t state_i,
  output csm_state_t state_o,
  output csm_res_t   res_o
);

  logic [2:0] prev;
  logic [5:0] sec;
  logic [5:0] min;
  logic       wr;
  logic       clr;
  logic [5:0] hrs_inc;
  logic [6:0] min_inc;
  logic [3:0] mon_mod;
  logic [4:0] day_len;
  logic [4:0] day_mod;
  logic [7:0] yr_inc;
  logic [4:0] run_len;

  always_comb begin
    prev    = state_i.menu;
    sec     = req_i.read_seconds;
    min     = req_i.read_minutes;
    wr      = 1'b0;
    clr     = 1'b0;
    state_o = state_i;

    hrs_inc = {1'b0, state_i.hours} + 6'd1;
    min_inc = {1'b0, req_i.read_minutes} + 7'd1;
    mon_mod = (state_i.month >= 4'd12) ? state_i.month - 4'd12 : state_i.month;
    day_len = csm_month_len(state_i.month, state_i.year);
    day_mod = (state_i.date >= day_len) ? state_i.date - day_len : state_i.date;
    yr_inc  = {1'b0, state_i.year} + 8'd1;
    run_len = csm_month_len(req_i.read_month, req_i.read_year);

    if (prev == MENU_RUN || prev == MENU_UNUSED) begin
      state_o.hours = req_i.read_hours;
      state_o.date  = req_i.read_date;
      state_o.month = req_i.read_month;
      state_o.year  = req_i.read_year;
      if (req_i.read_hours == 5'd0 && req_i.read_minutes == 6'd0 &&
          req_i.read_seconds == 6'd0 &&
          (req_i.read_month == MONTH_FEB || csm_short_month(req_i.read_month)) &&
          req_i.read_date > run_len) begin
        state_o.month = req_i.read_month + 4'd1;
        state_o.date  = 5'd1;
        wr            = 1'b1;
      end
      state_o.menu = req_i.mode_press ? MENU_HOURS : MENU_RUN;
    end else if (req_i.mode_press) begin
      if (prev == MENU_YEAR) begin
        state_o.menu = MENU_RUN;
        clr          = 1'b1;
      end else begin
        state_o.menu = prev + 3'd1;
      end
    end else if (req_i.up_press) begin
      wr = 1'b1;
      unique case (prev)
        MENU_HOURS: begin
          state_o.hours = (hrs_inc >= 6'd24) ? 5'(hrs_inc - 6'd24) : hrs_inc[4:0];
        end
        MENU_MINUTES: begin
          min = (min_inc >= 7'd60) ? 6'(min_inc - 7'd60) : min_inc[5:0];
        end
        MENU_SECONDS: begin
          sec = 6'd0;
        end
        MENU_MONTH: begin
          state_o.month = mon_mod + 4'd1;
        end
        MENU_DATE: begin
          state_o.date = day_mod + 5'd1;
        end
        default: begin
          state_o.year = (yr_inc >= 8'd100) ? 7'(yr_inc - 8'd100) : yr_inc[6:0];
        end
      endcase
    end

    res_o.shown_state   = prev;
    res_o.out_seconds   = sec;
    res_o.out_minutes   = min;
    res_o.out_hours     = state_o.hours;
    res_o.out_date      = state_o.date;
    res_o.out_month     = state_o.month;
    res_o.out_year      = state_o.year;
    res_o.write_strobe  = wr;
    res_o.clear_display = clr;
  end

endmodule

// ===== hdl/clock_set_menu_controller_top.sv =====
// ----------------------------------------------------------------------------
// Clock set menu controller
// Steps the seven-state time set menu once per clock poll request.
// ----------------------------------------------------------------------------
// One request is taken per cycle while the input is ready: the request is
// registered, then one pass of the step logic against the menu state and
// shadow record fills the result register. Back-pressure on the result side
// stalls both stages; the input is ready whenever the request stage is empty
// or moving on.
module clock_set_menu_controller_top import csm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  csm_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output csm_res_t out_res_o
);

  csm_req_t   req_q;
  logic       req_valid_q;
  csm_res_t   res_q;
  csm_res_t   res_d;
  logic       res_valid_q;
  csm_state_t state_q;
  csm_state_t state_d;
  logic       res_free;
  logic       step_en;

  assign res_free   = !res_valid_q || out_ready_i;
  assign step_en    = req_valid_q && res_free;
  assign in_ready_o = !req_valid_q || res_free;

  csm_step u_step (
    .req_i   (req_q),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      state_q     <= '{menu: MENU_RUN, hours: 5'd0, date: 5'd1, month: 4'd1,
                       year: 7'd0};
    end else begin
      if (in_ready_o) begin
        req_valid_q <= in_valid_i;
      end
      if (res_free) begin
        res_valid_q <= req_valid_q;
      end
      if (step_en) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
    if (step_en) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_res_o   = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.menu != MENU_UNUSED)
    else $error("menu state left the defined range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.clear_display |-> out_res_o.shown_state == MENU_YEAR)
    else $error("display clear outside year edit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_res_o.clear_display && out_res_o.write_strobe))
    else $error("write and display clear together");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.write_strobe && out_res_o.shown_state == MENU_RUN
    |-> out_res_o.out_date == 5'd1)
    else $error("run state write without date correction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_en |=> $stable(state_q))
    else $error("menu record changed without a request");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock set menu controller testbench
// Drives poll requests with random gaps and stalls into the menu controller,
// predicts every result from its own copy of the menu state and shadow
// record, and compares each result field by field as it leaves the block.
// Directed parts cover midnight date correction, field extremes, a full
// walk through the menu with every wrap and a long result stall; a random
// part follows.
// ----------------------------------------------------------------------------
module tb_top;
  import csm_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_POLLS = 1000;
  localparam int LONG_HOLD = 250;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  csm_req_t in_req_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  csm_res_t out_res_o;

  // predicted menu state and shadow record
  logic [2:0] menu_q = MENU_RUN;
  logic [4:0] hours_q = 5'd0;
  logic [4:0] date_q = 5'd1;
  logic [3:0] month_q = 4'd1;
  logic [6:0] year_q = 7'd0;

  csm_res_t expected_menu_results[$];

  int  cycle_count = 0;
  int  mismatches = 0;
  int  polls_sent = 0;
  int  results_seen = 0;
  int  write_backs = 0;
  int  menu_exits = 0;
  bit  steady_flow = 1'b0;
  bit  sink_hold_request = 1'b0;

  clock_set_menu_controller_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_menu_results.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic bit thirty_day(logic [3:0] month);
    return month == MONTH_APR || month == MONTH_JUN || month == MONTH_SEP ||
           month == MONTH_NOV;
  endfunction

  function automatic int days_in_month(logic [3:0] month, logic [6:0] year);
    if (month == MONTH_FEB) begin
      return (year % 4 == 0) ? 29 : 28;
    end
    return thirty_day(month) ? 30 : 31;
  endfunction

  function automatic csm_res_t step_menu(csm_req_t req);
    csm_res_t   res;
    logic [5:0] sec;
    logic [5:0] min;
    logic [2:0] prev;
    logic       wr;
    logic       clr;
    sec = req.read_seconds;
    min = req.read_minutes;
    prev = menu_q;
    wr = 1'b0;
    clr = 1'b0;
    if (prev == MENU_RUN || prev == MENU_UNUSED) begin
      hours_q = req.read_hours;
      date_q = req.read_date;
      month_q = req.read_month;
      year_q = req.read_year;
      if (req.read_hours == 0 && min == 0 && sec == 0 &&
          (req.read_month == MONTH_FEB || thirty_day(req.read_month)) &&
          req.read_date > days_in_month(req.read_month, req.read_year)) begin
        month_q = req.read_month + 4'd1;
        date_q = 5'd1;
        wr = 1'b1;
      end
      menu_q = req.mode_press ? MENU_HOURS : MENU_RUN;
    end else if (req.mode_press) begin
      if (prev == MENU_YEAR) begin
        menu_q = MENU_RUN;
        clr = 1'b1;
      end else begin
        menu_q = prev + 3'd1;
      end
    end else if (req.up_press) begin
      wr = 1'b1;
      case (prev)
        MENU_HOURS:   hours_q = 5'((hours_q + 1) % 24);
        MENU_MINUTES: min = 6'((min + 1) % 60);
        MENU_SECONDS: sec = 6'd0;
        MENU_MONTH:   month_q = 4'((month_q % 12) + 1);
        MENU_DATE:    date_q = 5'((date_q % days_in_month(month_q, year_q)) + 1);
        MENU_YEAR:    year_q = 7'((year_q + 1) % 100);
        default: ;
      endcase
    end
    res.shown_state = prev;
    res.out_seconds = sec;
    res.out_minutes = min;
    res.out_hours = hours_q;
    res.out_date = date_q;
    res.out_month = month_q;
    res.out_year = year_q;
    res.write_strobe = wr;
    res.clear_display = clr;
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("result %0d: %s got %0d, expected %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(csm_res_t got);
    csm_res_t want;
    if (expected_menu_results.size() == 0) begin
      report_mismatch("unexpected result, shown_state", 32'(got.shown_state), 0);
      return;
    end
    want = expected_menu_results.pop_front();
    if (got.shown_state !== want.shown_state)
      report_mismatch("shown_state", 32'(got.shown_state), 32'(want.shown_state));
    if (got.out_seconds !== want.out_seconds)
      report_mismatch("out_seconds", 32'(got.out_seconds), 32'(want.out_seconds));
    if (got.out_minutes !== want.out_minutes)
      report_mismatch("out_minutes", 32'(got.out_minutes), 32'(want.out_minutes));
    if (got.out_hours !== want.out_hours)
      report_mismatch("out_hours", 32'(got.out_hours), 32'(want.out_hours));
    if (got.out_date !== want.out_date)
      report_mismatch("out_date", 32'(got.out_date), 32'(want.out_date));
    if (got.out_month !== want.out_month)
      report_mismatch("out_month", 32'(got.out_month), 32'(want.out_month));
    if (got.out_year !== want.out_year)
      report_mismatch("out_year", 32'(got.out_year), 32'(want.out_year));
    if (got.write_strobe !== want.write_strobe)
      report_mismatch("write_strobe", 32'(got.write_strobe), 32'(want.write_strobe));
    if (got.clear_display !== want.clear_display)
      report_mismatch("clear_display", 32'(got.clear_display),
                      32'(want.clear_display));
  endtask

  // called at a rising edge; returns at the edge that accepts the request
  task automatic send_poll(csm_req_t req);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= req;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    expected_menu_results.push_back(step_menu(req));
    polls_sent++;
  endtask

  initial begin : result_sink
    int       hold;
    csm_res_t got;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      hold = steady_flow ? 0 : $urandom_range(0, 10);
      if (sink_hold_request) begin
        hold = LONG_HOLD;
        sink_hold_request = 1'b0;
      end
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(negedge clk_i); while (!out_valid_o);
      got = out_res_o;
      @(posedge clk_i);
      check_result(got);
      results_seen++;
      write_backs += int'(got.write_strobe);
      menu_exits += int'(got.clear_display);
    end
  end

  function automatic csm_req_t make_poll(int sec, int min, int hrs, int date, int month,
                                         int year, bit mode, bit up);
    csm_req_t r;
    r.read_seconds = 6'(sec);
    r.read_minutes = 6'(min);
    r.read_hours = 5'(hrs);
    r.read_date = 5'(date);
    r.read_month = 4'(month);
    r.read_year = 7'(year);
    r.mode_press = mode;
    r.up_press = up;
    return r;
  endfunction

  function automatic csm_req_t random_poll();
    csm_req_t    r;
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    r = noise[$bits(csm_req_t)-1:0];
    if ($urandom_range(0, 9) < 8) begin
      r.read_seconds = 6'($urandom_range(0, 59));
      r.read_minutes = 6'($urandom_range(0, 59));
      r.read_hours = 5'($urandom_range(0, 23));
      r.read_date = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(28, 31))
                                                  : 5'($urandom_range(1, 31));
      r.read_month = 4'($urandom_range(1, 12));
      r.read_year = 7'($urandom_range(0, 99));
      if ($urandom_range(0, 3) == 0) begin
        r.read_seconds = 6'd0;
        r.read_minutes = 6'd0;
        r.read_hours = 5'd0;
      end
    end
    r.mode_press = ($urandom_range(0, 3) == 0);
    r.up_press = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic test_midnight_correction();
    send_poll(make_poll(0, 0, 0, 29, 2, 1, 0, 0));
    send_poll(make_poll(0, 0, 0, 29, 2, 4, 0, 0));
    send_poll(make_poll(0, 0, 0, 30, 2, 0, 0, 0));
    send_poll(make_poll(0, 0, 0, 31, 4, 50, 0, 0));
    send_poll(make_poll(0, 0, 0, 31, 9, 127, 0, 0));
    send_poll(make_poll(0, 0, 0, 31, 11, 99, 0, 0));
    send_poll(make_poll(0, 0, 0, 31, 1, 23, 0, 0));
    send_poll(make_poll(1, 0, 0, 31, 2, 3, 0, 0));
  endtask

  task automatic test_field_extremes();
    send_poll(make_poll(63, 63, 31, 31, 15, 127, 0, 1));
    send_poll(make_poll(0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_menu_walk();
    send_poll(make_poll(59, 59, 23, 31, 12, 99, 1, 0));
    send_poll(make_poll(59, 59, 0, 0, 0, 0, 0, 1));
    send_poll(make_poll(10, 59, 0, 0, 0, 0, 1, 0));
    send_poll(make_poll(10, 59, 0, 0, 0, 0, 0, 1));
    send_poll(make_poll(10, 59, 0, 0, 0, 0, 1, 1));
    send_poll(make_poll(42, 7, 0, 0, 0, 0, 0, 1));
    send_poll(make_poll(42, 7, 0, 0, 0, 0, 1, 0));
    send_poll(make_poll(42, 7, 0, 0, 0, 0, 0, 1));
    send_poll(make_poll(42, 7, 0, 0, 0, 0, 1, 0));
    send_poll(make_poll(42, 7, 0, 0, 0, 0, 0, 1));
    send_poll(make_poll(42, 7, 0, 0, 0, 0, 1, 0));
    send_poll(make_poll(42, 7, 0, 0, 0, 0, 0, 1));
    send_poll(make_poll(42, 7, 0, 0, 0, 0, 1, 1));
  endtask

  task automatic test_back_pressure();
    sink_hold_request = 1'b1;
    steady_flow = 1'b1;
    repeat (40) send_poll(random_poll());
    steady_flow = 1'b0;
  endtask

  task automatic test_random_polls();
    for (int i = 0; i < RANDOM_POLLS; i++) begin
      steady_flow = ((i / 100) % 4 == 3);
      send_poll(random_poll());
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_midnight_correction();
    test_field_extremes();
    test_menu_walk();
    test_back_pressure();
    test_random_polls();
    in_valid_i <= 1'b0;
    while (expected_menu_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("run covered %0d poll requests and %0d results checked", polls_sent,
             results_seen);
    $display("including %0d write-backs and %0d exits from year edit, %0d mismatches",
             write_backs, menu_exits, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== clock_set_menu_controller_top.f =====
hdl/csm_pkg.sv
hdl/csm_step.sv
hdl/clock_set_menu_controller_top.sv
test/tb_top.sv
